// ===== rtl/mtfm_pkg.sv =====
// mtfm_pkg: shared types and constants for the topic filter matcher
// request and result payload structs, character codes, default store depth
// no dependencies
package mtfm_pkg;

  localparam int MAX_FILTER_LEN_DEF = 64;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic KIND_FILTER = 1'b0;
  localparam logic KIND_TOPIC  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic       last;
  } req_t;

  typedef struct packed {
    logic matched;
    logic filter_too_long;
  } res_t;

endpackage

// ===== rtl/mqtt_topic_filter_matcher_top.sv =====
// mqtt_topic_filter_matcher_top: loads a subscription filter and matches topics against it
// uses mtfm_pkg for payload types and character codes
// the result of the last topic character is registered in the output or skid entry
// one request per cycle unless stalled; the store read ports follow the updated position
// a result held behind a stalled result stalls requests until the output drains
// reset clears all control state; the store is not cleared, an empty filter matches nothing
module mqtt_topic_filter_matcher_top #(
  parameter int MAX_FILTER_LEN = mtfm_pkg::MAX_FILTER_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mtfm_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output mtfm_pkg::res_t res
);

  localparam int AW = (MAX_FILTER_LEN > 1) ? $clog2(MAX_FILTER_LEN) : 1;
  localparam int LW = $clog2(MAX_FILTER_LEN + 1);

  // filter store
  logic [7:0] store [MAX_FILTER_LEN];
  logic [7:0] rd0;
  logic [7:0] rd1;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  ra0;
  logic [AW-1:0]  ra1;

  // filter state
  logic [LW-1:0] flen;
  logic [LW-1:0] flen_next;
  logic          fcomplete;
  logic          fcomplete_next;
  logic          fovf;
  logic          fovf_next;
  logic          tail_hash;
  logic          tail_hash_next;
  logic          tail_slash;
  logic          tail_slash_next;
  logic          tail_slash_hash;
  logic          tail_slash_hash_next;

  // topic state
  logic [LW-1:0] pos;
  logic [LW-1:0] pos_next;
  logic          skipping;
  logic          skipping_next;
  logic          mismatch;
  logic          mismatch_next;
  logic          hash_hit;
  logic          hash_hit_next;

  // result buffer
  logic           skid_valid;
  mtfm_pkg::res_t skid;
  logic           new_valid;
  mtfm_pkg::res_t new_res;

  logic          accept;
  logic          restart;
  logic [LW-1:0] len_base;
  logic          f0v;
  logic          f1v;
  logic [LW:0]   pos_ext1;
  logic [LW:0]   len_ext;
  logic [LW:0]   pn_ext1;
  logic [LW:0]   pn_ext2;
  logic          rest_ok;

  assign req_stall = skid_valid;
  assign accept    = req_valid && !req_stall;

  assign len_ext  = {1'b0, flen};
  assign pos_ext1 = {1'b0, pos} + (LW+1)'(1);
  assign f0v      = pos < flen;
  assign f1v      = pos_ext1 < len_ext;
  assign restart  = fcomplete;
  assign len_base = restart ? '0 : flen;

  always_comb begin
    flen_next            = flen;
    fcomplete_next       = fcomplete;
    fovf_next            = fovf;
    tail_hash_next       = tail_hash;
    tail_slash_next      = tail_slash;
    tail_slash_hash_next = tail_slash_hash;
    pos_next             = pos;
    skipping_next        = skipping;
    mismatch_next        = mismatch;
    hash_hit_next        = hash_hit;
    we                   = 1'b0;
    waddr                = len_base[AW-1:0];
    new_valid            = 1'b0;
    new_res              = '0;
    pn_ext1              = '0;
    pn_ext2              = '0;
    rest_ok              = 1'b0;
    if (accept) begin
      if (req.kind == mtfm_pkg::KIND_FILTER) begin
        pos_next      = '0;
        skipping_next = 1'b0;
        mismatch_next = 1'b0;
        hash_hit_next = 1'b0;
        fovf_next     = restart ? 1'b0 : fovf;
        flen_next     = len_base;
        if (len_base < LW'(MAX_FILTER_LEN)) begin
          we                   = 1'b1;
          flen_next            = len_base + LW'(1);
          tail_hash_next       = req.char_code == mtfm_pkg::CH_HASH;
          tail_slash_hash_next = !restart && (flen != '0) && tail_slash &&
                                 (req.char_code == mtfm_pkg::CH_HASH);
          tail_slash_next      = req.char_code == mtfm_pkg::CH_SLASH;
        end else begin
          fovf_next = 1'b1;
        end
        fcomplete_next = req.last;
      end else begin
        if (mismatch || hash_hit) begin
          pos_next = pos;
        end else if (skipping) begin
          if (req.char_code == mtfm_pkg::CH_SLASH) begin
            skipping_next = 1'b0;
            if (f0v && rd0 == mtfm_pkg::CH_SLASH) begin
              pos_next = pos + LW'(1);
            end else begin
              mismatch_next = 1'b1;
            end
          end
        end else if (!f0v) begin
          mismatch_next = 1'b1;
        end else if (rd0 == mtfm_pkg::CH_HASH) begin
          hash_hit_next = 1'b1;
        end else if (rd0 == mtfm_pkg::CH_PLUS) begin
          pos_next      = pos + LW'(1);
          skipping_next = 1'b1;
          if (req.char_code == mtfm_pkg::CH_SLASH) begin
            skipping_next = 1'b0;
            if (f1v && rd1 == mtfm_pkg::CH_SLASH) begin
              pos_next = pos + LW'(2);
            end else begin
              mismatch_next = 1'b1;
            end
          end
        end else if (rd0 == req.char_code) begin
          pos_next = pos + LW'(1);
        end else begin
          mismatch_next = 1'b1;
        end
        if (req.last) begin
          pn_ext1 = {1'b0, pos_next} + (LW+1)'(1);
          pn_ext2 = {1'b0, pos_next} + (LW+1)'(2);
          rest_ok = (pos_next >= flen) || (pn_ext1 == len_ext && tail_hash) ||
                    (pn_ext2 == len_ext && tail_slash_hash);
          new_valid               = 1'b1;
          new_res.filter_too_long = fovf;
          new_res.matched         = !fovf && !mismatch_next && (hash_hit_next || rest_ok);
          pos_next                = '0;
          skipping_next           = 1'b0;
          mismatch_next           = 1'b0;
          hash_hit_next           = 1'b0;
        end
      end
    end
  end

  assign ra0 = pos_next[AW-1:0];
  assign ra1 = ra0 + AW'(1);

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= req.char_code;
    end
    rd0 <= (we && waddr == ra0) ? req.char_code : store[ra0];
    rd1 <= (we && waddr == ra1) ? req.char_code : store[ra1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flen            <= '0;
      fcomplete       <= 1'b1;
      fovf            <= 1'b0;
      tail_hash       <= 1'b0;
      tail_slash      <= 1'b0;
      tail_slash_hash <= 1'b0;
      pos             <= '0;
      skipping        <= 1'b0;
      mismatch        <= 1'b0;
      hash_hit        <= 1'b0;
    end else begin
      flen            <= flen_next;
      fcomplete       <= fcomplete_next;
      fovf            <= fovf_next;
      tail_hash       <= tail_hash_next;
      tail_slash      <= tail_slash_next;
      tail_slash_hash <= tail_slash_hash_next;
      pos             <= pos_next;
      skipping        <= skipping_next;
      mismatch        <= mismatch_next;
      hash_hit        <= hash_hit_next;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid  <= skid_valid || new_valid;
      skid_valid <= 1'b0;
    end else if (new_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      res <= skid_valid ? skid : new_res;
    end
    if (new_valid && res_valid && res_stall) begin
      skid <= new_res;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held without output entry");

  a_pos_in_filter: assert property (@(posedge clk) disable iff (rst)
    pos <= flen)
    else $error("filter position beyond filter length");

  a_last_topic_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && req.kind == mtfm_pkg::KIND_TOPIC && req.last) |=> res_valid)
    else $error("no result after last topic character");

  a_overflow_never_matches: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.filter_too_long) |-> !res.matched)
    else $error("overflowed filter reported a match");
`endif

endmodule
